// ===== design/emg_haptic_pattern_controller_unit_assert.svh =====
// Assertion macros shared by the haptic controller modules.
`ifndef EMG_HAPTIC_PATTERN_CONTROLLER_UNIT_ASSERT_SVH
`define EMG_HAPTIC_PATTERN_CONTROLLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EHPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ehpc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EHPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ehpc assertion failed");

`endif

// ===== design/ehpc_pkg.sv =====
`default_nettype none

package ehpc_pkg;

    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 16;
    localparam int LVL_W       = 7;
    localparam int NUM_W       = RAW_W + LVL_W;
    localparam int TIME_W      = 10;
    localparam int ROT_W       = 2;
    localparam int ACT_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int FRAME_BYTES_DEF = 11;
    localparam int EV_Q_DEPTH      = 2;
    localparam int RES_Q_DEPTH     = 2;

    // Byte positions inside a stored frame.
    localparam int TYPE_POS    = 0;
    localparam int RAW_ONE_LO  = 7;
    localparam int RAW_ONE_HI  = 8;
    localparam int RAW_TWO_LO  = 9;
    localparam int RAW_TWO_HI  = 10;

    localparam logic [BYTE_W-1:0] START_MARK     = 8'd170;
    localparam logic [BYTE_W-1:0] EMG_FRAME_TYPE = 8'd10;

    localparam logic [LVL_W-1:0]  LEVEL_MAX   = 7'd100;
    localparam logic [LVL_W-1:0]  LEVEL_SCALE = 7'd100;
    localparam logic [TIME_W-1:0] ELAPSED_MAX = 10'd1023;
    localparam logic [TIME_W-1:0] COCON_REST  = 10'd50;
    localparam logic [TIME_W-1:0] REST_BASE   = 10'd700;
    localparam logic [TIME_W-1:0] REST_SLOPE  = 10'd6;
    localparam logic [ROT_W-1:0]  ROT_LAST    = 2'd2;

    localparam logic [ACT_W-1:0]  ACT_COCON_A  = 3'd0;
    localparam logic [ACT_W-1:0]  ACT_COCON_B  = 3'd3;
    localparam logic [ACT_W-1:0]  ACT_BASE_ONE = 3'd3;

    localparam logic [RAW_W-1:0]  FULL_SCALE_RST = 16'd185;
    localparam logic [LVL_W-1:0]  ACT_LEVEL_RST  = 7'd20;
    localparam logic [LVL_W-1:0]  BAND_RST       = 7'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_SCALE_ONE = 2'd0,
        CFG_FULL_SCALE_TWO = 2'd1,
        CFG_ACT_LEVEL      = 2'd2,
        CFG_BALANCE_BAND   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [ACT_W-1:0] actuator;
        logic             last;
    } t_out_word;

    typedef struct packed {
        logic             is_tick;
        logic [RAW_W-1:0] raw_one;
        logic [RAW_W-1:0] raw_two;
    } t_ev_word;

    typedef struct packed {
        logic [RAW_W-1:0] full_scale_one;
        logic [RAW_W-1:0] full_scale_two;
        logic [LVL_W-1:0] activation_level;
        logic [LVL_W-1:0] balance_band;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== design/ehpc_queue.sv =====
`default_nettype none

`include "emg_haptic_pattern_controller_unit_assert.svh"

module ehpc_queue #(
    parameter type T     = logic [7:0],
    parameter int  DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire T                 i_data,
    input  wire logic             i_pop,
    output T                      o_data,
    output ehpc_pkg::t_q_stat     o_stat
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CntW'(DEPTH));
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `EHPC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CntW'(DEPTH))

endmodule

`default_nettype wire

// ===== design/ehpc_front.sv =====
`default_nettype none

module ehpc_front #(
    parameter int FRAME_BYTES = ehpc_pkg::FRAME_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire ehpc_pkg::t_in_word i_in_word,
    input  wire ehpc_pkg::t_q_stat  i_ev_stat,
    output logic                    o_full,
    output logic                    o_ev_push,
    output ehpc_pkg::t_ev_word      o_ev_word
);

    localparam int CntW = $clog2(FRAME_BYTES + 1);
    localparam int IdxW = $clog2(FRAME_BYTES);

    logic                        r_receiving;
    logic [CntW-1:0]             r_byte_pos;
    logic [ehpc_pkg::BYTE_W-1:0] r_store [FRAME_BYTES];

    logic w_accept;
    logic w_byte;
    logic w_room;
    logic w_store;
    logic w_close;

    assign o_full   = i_ev_stat.full;
    assign w_accept = i_push && !i_ev_stat.full;
    assign w_byte   = w_accept && !i_in_word.kind;
    assign w_room   = (r_byte_pos < CntW'(FRAME_BYTES));
    assign w_store  = w_byte && r_receiving && w_room;
    assign w_close  = w_byte && r_receiving && !w_room;

    // Ticks pass straight through; a closed frame goes on only if it carries readings.
    assign o_ev_push = w_accept && (i_in_word.kind ||
                       (w_close && (r_store[ehpc_pkg::TYPE_POS] == ehpc_pkg::EMG_FRAME_TYPE)));
    assign o_ev_word.is_tick = i_in_word.kind;
    assign o_ev_word.raw_one = {r_store[ehpc_pkg::RAW_ONE_HI], r_store[ehpc_pkg::RAW_ONE_LO]};
    assign o_ev_word.raw_two = {r_store[ehpc_pkg::RAW_TWO_HI], r_store[ehpc_pkg::RAW_TWO_LO]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_byte_pos  <= '0;
        end else if (w_byte) begin
            if (!r_receiving) begin
                if (i_in_word.rx_byte == ehpc_pkg::START_MARK) begin
                    r_receiving <= 1'b1;
                    r_byte_pos  <= '0;
                end
            end else if (w_room) begin
                r_byte_pos <= r_byte_pos + 1'b1;
            end else begin
                r_receiving <= 1'b0;
                r_byte_pos  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_store[r_byte_pos[IdxW-1:0]] <= i_in_word.rx_byte;
        end
    end

endmodule

`default_nettype wire

// ===== design/ehpc_back.sv =====
`default_nettype none

`include "emg_haptic_pattern_controller_unit_assert.svh"

module ehpc_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ehpc_pkg::t_cfg      i_cfg,
    input  wire ehpc_pkg::t_ev_word  i_ev_word,
    input  wire ehpc_pkg::t_q_stat   i_ev_stat,
    output logic                     o_ev_pop,
    input  wire ehpc_pkg::t_q_stat   i_res_stat,
    output logic                     o_res_push,
    output ehpc_pkg::t_out_word      o_res_word
);

    localparam int RawW  = ehpc_pkg::RAW_W;
    localparam int LvlW  = ehpc_pkg::LVL_W;
    localparam int NumW  = ehpc_pkg::NUM_W;
    localparam int TimeW = ehpc_pkg::TIME_W;
    localparam int RotW  = ehpc_pkg::ROT_W;
    localparam int ActW  = ehpc_pkg::ACT_W;
    localparam int StepW = $clog2(LvlW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SAT,
        S_DIV,
        S_LVL,
        S_EVAL,
        S_EMIT
    } t_state;

    // Control state
    t_state           r_state,     n_state;
    logic [1:0]       r_ready,     n_ready;
    logic [TimeW-1:0] r_elapsed [2];
    logic [TimeW-1:0] n_elapsed [2];
    logic [TimeW-1:0] r_rest [2];
    logic [TimeW-1:0] n_rest [2];
    logic [RotW-1:0]  r_rot [2];
    logic [RotW-1:0]  n_rot [2];
    logic [StepW-1:0] r_step,      n_step;
    logic             r_emit_idx,  n_emit_idx;
    logic             r_emit_last, n_emit_last;

    // Datapath
    logic [RawW-1:0]  r_raw [2];
    logic [RawW-1:0]  n_raw [2];
    logic [NumW-1:0]  r_num [2];
    logic [NumW-1:0]  n_num [2];
    logic [NumW-1:0]  r_rem [2];
    logic [NumW-1:0]  n_rem [2];
    logic [LvlW-1:0]  r_q [2];
    logic [LvlW-1:0]  n_q [2];
    logic [1:0]       r_sat,       n_sat;
    logic [LvlW-1:0]  r_lvl [2];
    logic [LvlW-1:0]  n_lvl [2];
    ehpc_pkg::t_out_word r_res0, n_res0;
    ehpc_pkg::t_out_word r_res1, n_res1;

    // Per-channel helpers
    logic [RawW-1:0]  w_fs [2];
    logic [NumW-1:0]  w_trial [2];
    logic [1:0]       w_ge;
    logic [TimeW-1:0] w_e_inc [2];
    logic [1:0]       w_act;
    logic [1:0]       w_fire;
    logic [RotW-1:0]  w_pos [2];
    logic [RotW-1:0]  w_pos_next [2];
    logic [TimeW-1:0] w_rest_new [2];
    logic [LvlW-1:0]  w_diff;
    logic             w_cocon;

    assign w_fs[0] = i_cfg.full_scale_one;
    assign w_fs[1] = i_cfg.full_scale_two;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_trial[i] = NumW'(w_fs[i]) << r_step;
            w_ge[i]    = (r_rem[i] >= w_trial[i]);
            w_e_inc[i] = (r_elapsed[i] == ehpc_pkg::ELAPSED_MAX) ? r_elapsed[i]
                                                                 : r_elapsed[i] + 1'b1;
            w_act[i]   = (r_lvl[i] >= i_cfg.activation_level);
            // Position three never occurs in normal use; it restarts the rotation.
            w_pos[i]      = (r_rot[i] > ehpc_pkg::ROT_LAST) ? '0 : r_rot[i];
            w_pos_next[i] = (w_pos[i] == ehpc_pkg::ROT_LAST) ? '0 : w_pos[i] + 1'b1;
            w_rest_new[i] = ehpc_pkg::REST_BASE -
                            ehpc_pkg::REST_SLOPE * TimeW'(r_lvl[i]);
        end
    end

    assign w_diff  = (r_lvl[0] > r_lvl[1]) ? r_lvl[0] - r_lvl[1] : r_lvl[1] - r_lvl[0];
    assign w_cocon = w_act[0] && w_act[1] && (w_diff <= i_cfg.balance_band);
    assign w_fire  = w_cocon ? 2'b00 : (w_act & r_ready);

    assign o_res_word = r_emit_idx ? r_res1 : r_res0;

    always_comb begin
        n_state     = r_state;
        n_ready     = r_ready;
        n_elapsed   = r_elapsed;
        n_rest      = r_rest;
        n_rot       = r_rot;
        n_step      = r_step;
        n_emit_idx  = r_emit_idx;
        n_emit_last = r_emit_last;
        n_raw       = r_raw;
        n_num       = r_num;
        n_rem       = r_rem;
        n_q         = r_q;
        n_sat       = r_sat;
        n_lvl       = r_lvl;
        n_res0      = r_res0;
        n_res1      = r_res1;
        o_ev_pop    = 1'b0;
        o_res_push  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_ev_stat.empty) begin
                    o_ev_pop = 1'b1;
                    if (i_ev_word.is_tick) begin
                        for (int i = 0; i < 2; i++) begin
                            n_elapsed[i] = w_e_inc[i];
                            if (w_e_inc[i] > r_rest[i]) begin
                                n_ready[i] = 1'b1;
                            end
                        end
                    end else begin
                        n_raw[0] = i_ev_word.raw_one;
                        n_raw[1] = i_ev_word.raw_two;
                        // With neither channel ready the frame changes nothing.
                        if (r_ready != 2'b00) begin
                            n_state = S_MUL;
                        end
                    end
                end
            end
            S_MUL: begin
                for (int i = 0; i < 2; i++) begin
                    n_num[i] = NumW'(r_raw[i]) * NumW'(ehpc_pkg::LEVEL_SCALE);
                end
                n_state = S_SAT;
            end
            S_SAT: begin
                // A quotient of 128 or more clamps anyway, so seven quotient bits suffice.
                for (int i = 0; i < 2; i++) begin
                    n_sat[i] = (w_fs[i] == '0) || (r_num[i] >= {w_fs[i], LvlW'(0)});
                    n_rem[i] = r_num[i];
                    n_q[i]   = '0;
                end
                n_step  = StepW'(LvlW - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                for (int i = 0; i < 2; i++) begin
                    n_q[i] = {r_q[i][LvlW-2:0], w_ge[i]};
                    if (w_ge[i]) begin
                        n_rem[i] = r_rem[i] - w_trial[i];
                    end
                end
                if (r_step == '0) begin
                    n_state = S_LVL;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_LVL: begin
                for (int i = 0; i < 2; i++) begin
                    n_lvl[i] = (r_sat[i] || (r_q[i] > ehpc_pkg::LEVEL_MAX))
                               ? ehpc_pkg::LEVEL_MAX : r_q[i];
                end
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_ready = 2'b00;
                for (int i = 0; i < 2; i++) begin
                    if (r_ready[i]) begin
                        n_elapsed[i] = '0;
                    end
                    if (w_fire[i]) begin
                        n_rest[i] = w_rest_new[i];
                        n_rot[i]  = w_pos_next[i];
                    end
                end
                n_emit_idx = 1'b0;
                n_state    = S_EMIT;
                if (w_cocon) begin
                    n_rest[0]       = ehpc_pkg::COCON_REST;
                    n_rest[1]       = ehpc_pkg::COCON_REST;
                    n_res0.actuator = ehpc_pkg::ACT_COCON_A;
                    n_res0.last     = 1'b0;
                    n_res1.actuator = ehpc_pkg::ACT_COCON_B;
                    n_res1.last     = 1'b1;
                    n_emit_last     = 1'b1;
                end else if (w_fire[0]) begin
                    n_res0.actuator = ehpc_pkg::ACT_BASE_ONE + ActW'(w_pos[0]);
                    n_res0.last     = !w_fire[1];
                    n_res1.actuator = ActW'(w_pos[1]);
                    n_res1.last     = 1'b1;
                    n_emit_last     = w_fire[1];
                end else if (w_fire[1]) begin
                    n_res0.actuator = ActW'(w_pos[1]);
                    n_res0.last     = 1'b1;
                    n_emit_last     = 1'b0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!i_res_stat.full) begin
                    o_res_push = 1'b1;
                    if (r_emit_idx == r_emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_emit_idx = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 2'b11;
            r_elapsed   <= '{default: '0};
            r_rest      <= '{default: '0};
            r_rot       <= '{default: '0};
            r_step      <= '0;
            r_emit_idx  <= 1'b0;
            r_emit_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ready     <= n_ready;
            r_elapsed   <= n_elapsed;
            r_rest      <= n_rest;
            r_rot       <= n_rot;
            r_step      <= n_step;
            r_emit_idx  <= n_emit_idx;
            r_emit_last <= n_emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw  <= n_raw;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_sat  <= n_sat;
        r_lvl  <= n_lvl;
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

    `EHPC_ASSERT_NOW(a_lvl_range, i_clk, i_rst_n, r_state == S_EVAL, (r_lvl[0] <= ehpc_pkg::LEVEL_MAX) && (r_lvl[1] <= ehpc_pkg::LEVEL_MAX))
    `EHPC_ASSERT_NOW(a_eval_has_ready, i_clk, i_rst_n, r_state == S_EVAL, r_ready[0] || r_ready[1])
    `EHPC_ASSERT_NEXT(a_eval_clears_ready, i_clk, i_rst_n, r_state == S_EVAL, r_ready == 2'b00)

endmodule

`default_nettype wire

// ===== design/emg_haptic_pattern_controller_unit.sv =====
`default_nettype none

// Haptic pattern controller driven by two muscle-activity channels. Words pushed
// in are either received serial bytes or one-millisecond ticks; words popped out
// name the actuator to pulse, with last set on the final pulse caused by one
// input word. The receiver takes one word per cycle while the event queue is not
// full and assembles frames that open on byte 170; a closed measurement frame or
// a tick is handed through a two-entry queue to the evaluation engine. The engine
// takes a new word only when idle. A measurement frame with a ready channel goes
// through fetch, multiply, clamp check, seven restoring divide steps run on both
// channels side by side, level clamp and the pulse decision, then writes each
// pulse to the two-entry result queue, waiting while it is full. Full-scale,
// activation and balance registers are written through the configuration port;
// the user must write them only while the block is idle, which it does not enforce.
module emg_haptic_pattern_controller_unit #(
    parameter int FRAME_BYTES = ehpc_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire ehpc_pkg::t_in_word            i_in_word,
    output logic                               empty,
    input  wire logic                          pop,
    output ehpc_pkg::t_out_word                o_out_word,
    input  wire logic                          i_cfg_we,
    input  wire logic [ehpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ehpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RawW = ehpc_pkg::RAW_W;
    localparam int LvlW = ehpc_pkg::LVL_W;

    ehpc_pkg::t_cfg      r_cfg;
    ehpc_pkg::t_ev_word  w_ev_in;
    ehpc_pkg::t_ev_word  w_ev_out;
    ehpc_pkg::t_q_stat   w_ev_stat;
    ehpc_pkg::t_q_stat   w_res_stat;
    ehpc_pkg::t_out_word w_res_word;
    logic                w_ev_push;
    logic                w_ev_pop;
    logic                w_res_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_scale_one   <= ehpc_pkg::FULL_SCALE_RST;
            r_cfg.full_scale_two   <= ehpc_pkg::FULL_SCALE_RST;
            r_cfg.activation_level <= ehpc_pkg::ACT_LEVEL_RST;
            r_cfg.balance_band     <= ehpc_pkg::BAND_RST;
        end else if (i_cfg_we) begin
            unique case (ehpc_pkg::t_cfg_idx'(i_cfg_idx))
                ehpc_pkg::CFG_FULL_SCALE_ONE: r_cfg.full_scale_one   <= i_cfg_data[RawW-1:0];
                ehpc_pkg::CFG_FULL_SCALE_TWO: r_cfg.full_scale_two   <= i_cfg_data[RawW-1:0];
                ehpc_pkg::CFG_ACT_LEVEL:      r_cfg.activation_level <= i_cfg_data[LvlW-1:0];
                ehpc_pkg::CFG_BALANCE_BAND:   r_cfg.balance_band     <= i_cfg_data[LvlW-1:0];
                default: begin
                end
            endcase
        end
    end

    ehpc_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_word (i_in_word),
        .i_ev_stat (w_ev_stat),
        .o_full    (full),
        .o_ev_push (w_ev_push),
        .o_ev_word (w_ev_in)
    );

    ehpc_queue #(
        .T     (ehpc_pkg::t_ev_word),
        .DEPTH (ehpc_pkg::EV_Q_DEPTH)
    ) u_ev_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ev_push),
        .i_data  (w_ev_in),
        .i_pop   (w_ev_pop),
        .o_data  (w_ev_out),
        .o_stat  (w_ev_stat)
    );

    ehpc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_ev_word  (w_ev_out),
        .i_ev_stat  (w_ev_stat),
        .o_ev_pop   (w_ev_pop),
        .i_res_stat (w_res_stat),
        .o_res_push (w_res_push),
        .o_res_word (w_res_word)
    );

    ehpc_queue #(
        .T     (ehpc_pkg::t_out_word),
        .DEPTH (ehpc_pkg::RES_Q_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_word),
        .i_pop   (pop),
        .o_data  (o_out_word),
        .o_stat  (w_res_stat)
    );

    assign empty = w_res_stat.empty;

endmodule

`default_nettype wire
